/* rtl/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned ILE_CAPACITY = 64;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned ST_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_PUSH_TAIL = 3'd2,
    OP_INSERT    = 3'd3,
    OP_REMOVE    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

/* rtl/ile_if.sv */
// ----------------------------------------------------------------------------
// ile_req_if / ile_rsp_if
// Valid/ready channels for list requests and their results.
// ----------------------------------------------------------------------------
interface ile_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [6:0]         position;
  logic signed [31:0] item_value;

  modport source (output valid, output operation, output position, output item_value,
                  input ready);
  modport sink   (input valid, input operation, input position, input item_value,
                  output ready);
endinterface

interface ile_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [6:0]         entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

/* rtl/indexed_list_engine.sv */
// sequence: a read passes S_READ and S_TAKE, then S_RESP registers the result;
//   out-of-range and full requests go straight to S_RESP; insert and delete shift
//   k entries by one place (up to CAPACITY-1), and insert then writes the value in S_PUT
// throughput: one request at a time; the shift loop moves one entry per S_SHRD/S_SHWR pair
//   through the single read and write port of the entry ram
// reset: rst_ni is asynchronous, active low, and empties the list; no ram clearing
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit entries with positional read, insert, delete.
// ----------------------------------------------------------------------------
module indexed_list_engine import ile_pkg::*; #(
  parameter int unsigned CAPACITY = ILE_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ile_req_if.sink    req_i,
  ile_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TAKE,
    S_SHRD,
    S_SHWR,
    S_PUT,
    S_RESP
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     at_q;
  logic              ins_q;
  logic [VAL_W-1:0]  val_q;
  logic [VAL_W-1:0]  res_value_q;
  status_e           res_status_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_value_q;
  logic [ST_W-1:0]   out_status_q;
  logic [POS_W-1:0]  out_count_q;

  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic [PW-1:0]     at_ext;
  logic              rd_ok;
  logic              full;
  logic              req_beat;
  logic              rsp_beat;
  op_e               op;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  assign op       = op_e'(req_i.operation);
  assign pos_ext  = PW'(req_i.position);
  assign cnt_ext  = PW'(count_q);
  assign rd_ok    = pos_ext < cnt_ext;
  assign full     = count_q == CW'(CAPACITY);
  assign req_beat = req_i.valid && req_i.ready;
  assign rsp_beat = rsp_o.valid && rsp_o.ready;

  always_comb begin
    unique case (op)
      OP_PUSH_HEAD: at_ext = '0;
      OP_PUSH_TAIL: at_ext = cnt_ext;
      default:      at_ext = pos_ext;
    endcase
  end

  // one entry moves per read/write pair; on insert the value itself goes in last
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    unique case (state_q)
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = ins_q ? idx_q + AW'(1) : idx_q - AW'(1);
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = at_q;
        ram_wdata = val_q;
      end
      default: ;
    endcase
  end

  ile_ram #(
    .Width (VAL_W),
    .Depth (CAPACITY)
  ) u_ile_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      at_q         <= '0;
      ins_q        <= 1'b0;
      val_q        <= '0;
      res_value_q  <= '0;
      res_status_q <= ST_DONE;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= '0;
      out_count_q  <= '0;
    end else begin
      // a beat taken in S_RESP is refilled below
      if (rsp_beat && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_beat) begin
            val_q <= req_i.item_value;
            at_q  <= AW'(at_ext);
            unique case (op)
              OP_READ: begin
                if (rd_ok) begin
                  res_status_q <= ST_DONE;
                  idx_q        <= AW'(pos_ext);
                  state_q      <= S_READ;
                end else begin
                  res_value_q  <= '1;
                  res_status_q <= ST_RANGE;
                  state_q      <= S_RESP;
                end
              end
              OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT: begin
                res_value_q <= '0;
                // position is checked before fullness
                if (at_ext > cnt_ext) begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_RESP;
                end else if (full) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= ST_DONE;
                  ins_q        <= 1'b1;
                  if (cnt_ext > at_ext) begin
                    idx_q   <= AW'(count_q - CW'(1));
                    state_q <= S_SHRD;
                  end else begin
                    state_q <= S_PUT;
                  end
                end
              end
              OP_REMOVE: begin
                res_value_q <= '0;
                if (rd_ok) begin
                  res_status_q <= ST_DONE;
                  ins_q        <= 1'b0;
                  if (pos_ext + PW'(1) != cnt_ext) begin
                    idx_q   <= AW'(pos_ext + PW'(1));
                    state_q <= S_SHRD;
                  end else begin
                    count_q <= count_q - CW'(1);
                    state_q <= S_RESP;
                  end
                end else begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_RESP;
                end
              end
              default: begin
                res_value_q  <= '0;
                res_status_q <= ST_DONE;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        S_READ: state_q <= S_TAKE;
        S_TAKE: begin
          res_value_q <= ram_rdata;
          state_q     <= S_RESP;
        end
        S_SHRD: state_q <= S_SHWR;
        S_SHWR: begin
          if (ins_q) begin
            if (idx_q == at_q) begin
              state_q <= S_PUT;
            end else begin
              idx_q   <= idx_q - AW'(1);
              state_q <= S_SHRD;
            end
          end else begin
            if (CW'(idx_q) + CW'(1) == count_q) begin
              count_q <= count_q - CW'(1);
              state_q <= S_RESP;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_SHRD;
            end
          end
        end
        S_PUT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= res_value_q;
            out_status_q <= res_status_q;
            out_count_q  <= POS_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;

endmodule

/* rtl/ile_ram.sv */
// ----------------------------------------------------------------------------
// ile_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ile_checker.sv */
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks of the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ile_checker import ile_pkg::*; #(
  parameter int unsigned Capacity = ILE_CAPACITY
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [VAL_W-1:0]  rsp_value_i,
  input logic [ST_W-1:0]   rsp_status_i,
  input logic [POS_W-1:0]  rsp_count_i
);

  logic             req_beat;
  logic             rsp_beat;
  logic [1:0]       pending_q;
  logic             seen_q;
  logic [POS_W-1:0] last_count_q;

  assign req_beat = req_valid_i && req_ready_i;
  assign rsp_beat = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      seen_q       <= 1'b0;
      last_count_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(req_beat) - 2'(rsp_beat);
      if (rsp_beat) begin
        seen_q       <= 1'b1;
        last_count_q <= rsp_count_i;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i)
      && $stable(rsp_status_i) && $stable(rsp_count_i))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat |=> !req_ready_i)
    else $error("request taken while the previous one is in work");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 2'd0)
    else $error("result without a pending request");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_count_i == POS_W'(Capacity))
    else $error("full status with list not at capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_beat && seen_q |-> rsp_count_i == last_count_q
      || rsp_count_i == last_count_q + POS_W'(1)
      || rsp_count_i + POS_W'(1) == last_count_q)
    else $error("count moved by more than one between results");

endmodule

bind indexed_list_engine ile_checker #(
  .Capacity (CAPACITY)
) u_ile_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_value_i  (rsp_o.read_value),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.entry_count)
);
